// ----- src/eia_pkg.sv -----
// ----------------------------------------------------------------------------
// eia_pkg
// Shared types, operation codes and element-type helpers of the integer ALU.
// ----------------------------------------------------------------------------
package eia_pkg;

    localparam int unsigned DataW = 64;
    localparam int unsigned CntW  = 7;

    // Operation codes
    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_POW = 3'd4;
    localparam logic [2:0] OP_NEG = 3'd5;
    // Unassigned operation codes; they produce a zero result.
    localparam logic [2:0] OP_RSVD6 = 3'd6;
    localparam logic [2:0] OP_RSVD7 = 3'd7;

    // Element type codes
    localparam logic [2:0] ET_I8  = 3'd0;
    localparam logic [2:0] ET_U8  = 3'd1;
    localparam logic [2:0] ET_I16 = 3'd2;
    localparam logic [2:0] ET_U16 = 3'd3;
    localparam logic [2:0] ET_I32 = 3'd4;
    localparam logic [2:0] ET_U32 = 3'd5;
    localparam logic [2:0] ET_I64 = 3'd6;
    localparam logic [2:0] ET_U64 = 3'd7;

    // Configuration register indexes
    localparam logic CFG_OPERATION = 1'b0;
    localparam logic CFG_ELEM_TYPE = 1'b1;

    localparam logic [2:0] ELEM_TYPE_RESET = ET_I32;

    // Controller to datapath commands
    typedef struct packed {
        logic load;      // capture operands and set up the operation
        logic step;      // run one iteration of the shared unit
        logic finish;    // form the final result
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic iterative; // operation needs iterations
        logic done;      // iterations are complete
    } t_status;

    // Element width in bits
    function automatic logic [CntW-1:0] elem_width(input logic [2:0] et);
        logic [CntW-1:0] w;
        unique case (et[2:1])
            2'd0:    w = 7'd8;
            2'd1:    w = 7'd16;
            2'd2:    w = 7'd32;
            default: w = 7'd64;
        endcase
        return w;
    endfunction

    // Mask of the element width
    function automatic logic [DataW-1:0] elem_mask(input logic [2:0] et);
        logic [DataW-1:0] m;
        unique case (et[2:1])
            2'd0:    m = 64'h0000_0000_0000_00FF;
            2'd1:    m = 64'h0000_0000_0000_FFFF;
            2'd2:    m = 64'h0000_0000_FFFF_FFFF;
            default: m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

    // Sign bit of a value at the element width
    function automatic logic elem_sign(input logic [DataW-1:0] v, input logic [2:0] et);
        logic s;
        unique case (et[2:1])
            2'd0:    s = v[7];
            2'd1:    s = v[15];
            2'd2:    s = v[31];
            default: s = v[63];
        endcase
        return s;
    endfunction

endpackage

// ----- src/eia_stream_if.sv -----
// ----------------------------------------------------------------------------
// eia_stream_if
// Valid/ready channel carrying one operand pair or one result.
// ----------------------------------------------------------------------------
interface eia_in_if;
    logic                       valid;
    logic                       ready;
    logic [eia_pkg::DataW-1:0]  lhs_value;
    logic [eia_pkg::DataW-1:0]  rhs_value;
    logic                       last_element;

    modport source (output valid, lhs_value, rhs_value, last_element, input ready);
    modport sink   (input valid, lhs_value, rhs_value, last_element, output ready);
endinterface

interface eia_out_if;
    logic                       valid;
    logic                       ready;
    logic [eia_pkg::DataW-1:0]  result_value;
    logic                       divide_by_zero;
    logic                       last_out;

    modport source (output valid, result_value, divide_by_zero, last_out, input ready);
    modport sink   (input valid, result_value, divide_by_zero, last_out, output ready);
endinterface

// ----- src/eia_datapath.sv -----
// ----------------------------------------------------------------------------
// eia_datapath
// Operand registers, a shared 64-bit multiplier cut into 32x32 partial
// products, a radix-2 restoring divider and the square-and-multiply loop.
// ----------------------------------------------------------------------------
module eia_datapath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  eia_pkg::t_cmd              i_cmd,
    input  logic [2:0]                 i_operation,
    input  logic [2:0]                 i_elem_type,
    input  logic [eia_pkg::DataW-1:0]  i_lhs,
    input  logic [eia_pkg::DataW-1:0]  i_rhs,
    output eia_pkg::t_status           o_status,
    output logic [eia_pkg::DataW-1:0]  o_result,
    output logic                       o_div_zero
);

    localparam int unsigned W = eia_pkg::DataW;

    // Multiply-phase codes: each 64x64 low product takes three partial products.
    localparam logic [2:0] MP_IDLE = 3'd0;
    localparam logic [2:0] MP_LL   = 3'd1;
    localparam logic [2:0] MP_LH   = 3'd2;
    localparam logic [2:0] MP_HL   = 3'd3;
    localparam logic [2:0] MP_DONE = 3'd4;

    logic [2:0]          r_op, r_et;
    logic [W-1:0]        r_a, r_b, n_a, n_b;     // multiplicands / divisor
    logic [W-1:0]        r_acc, n_acc;           // result or quotient
    logic [W-1:0]        r_rem, n_rem;           // remainder or exponent
    logic [W-1:0]        r_base, n_base;         // pow base
    logic [W-1:0]        r_prod, n_prod;         // product accumulator
    logic [2:0]          r_mp, n_mp;
    logic                r_sq, n_sq;             // pow: 0 multiply, 1 square
    logic [eia_pkg::CntW-1:0] r_cnt, n_cnt;
    logic                r_neg, n_neg, r_dz, n_dz, r_zero, n_zero;
    logic [W-1:0]        r_res, n_res;

    logic [W-1:0]        mask;
    logic [31:0]         mul_x, mul_y;
    logic [63:0]         mul_p;
    logic [W:0]          rem_sh;
    logic [W-1:0]        a_m, b_m, a_abs, b_abs;
    logic                a_s, b_s, sgn;

    assign mask = eia_pkg::elem_mask(i_elem_type);
    assign sgn  = ~i_elem_type[0];
    assign a_m  = i_lhs & mask;
    assign b_m  = i_rhs & mask;
    assign a_s  = sgn & eia_pkg::elem_sign(a_m, i_elem_type);
    assign b_s  = sgn & eia_pkg::elem_sign(b_m, i_elem_type);
    assign a_abs = a_s ? ((W'(0) - a_m) & mask) : a_m;
    assign b_abs = b_s ? ((W'(0) - b_m) & mask) : b_m;

    // One 32x32 multiplier, operand halves selected by the phase.
    always_comb begin
        case (r_mp)
            MP_LH:   begin mul_x = r_a[31:0];  mul_y = r_b[63:32]; end
            MP_HL:   begin mul_x = r_a[63:32]; mul_y = r_b[31:0];  end
            default: begin mul_x = r_a[31:0];  mul_y = r_b[31:0];  end
        endcase
    end
    assign mul_p  = mul_x * mul_y;
    assign rem_sh = {r_rem, r_acc[W-1]};

    // Next-state datapath logic
    always_comb begin
        n_a = r_a; n_b = r_b; n_acc = r_acc; n_rem = r_rem; n_base = r_base;
        n_prod = r_prod; n_mp = r_mp; n_sq = r_sq; n_cnt = r_cnt;
        n_neg = r_neg; n_dz = r_dz; n_zero = r_zero; n_res = r_res;
        if (i_cmd.load) begin
            n_dz = 1'b0; n_zero = 1'b0; n_neg = 1'b0; n_mp = MP_IDLE; n_sq = 1'b0;
            n_cnt = eia_pkg::elem_width(i_elem_type);
            n_a = a_m; n_b = b_m; n_acc = '0; n_rem = '0; n_prod = '0;
            case (i_operation)
                eia_pkg::OP_ADD: n_res = (a_m + b_m) & mask;
                eia_pkg::OP_SUB: n_res = (a_m - b_m) & mask;
                eia_pkg::OP_NEG: n_res = (W'(0) - a_m) & mask;
                eia_pkg::OP_MUL: n_mp = MP_LL;
                eia_pkg::OP_DIV: begin
                    n_dz  = (b_m == '0);
                    n_neg = a_s ^ b_s;
                    // dividend bits shift out of acc's top, quotient bits in at bottom
                    n_acc = a_abs << (W - 32'(eia_pkg::elem_width(i_elem_type)));
                    n_b   = b_abs;
                    n_res = '0;
                end
                eia_pkg::OP_POW: begin
                    n_zero = b_s;
                    n_acc  = 64'd1;
                    n_base = a_m;
                    n_rem  = b_m;
                end
                default: n_res = '0;
            endcase
        end else if (i_cmd.step) begin
            if (r_op == eia_pkg::OP_MUL || (r_op == eia_pkg::OP_POW && r_mp != MP_IDLE)) begin
                // Low 64 bits of a*b from three partial products
                case (r_mp)
                    MP_LL: begin n_prod = mul_p; n_mp = MP_LH; end
                    MP_LH: begin n_prod = r_prod + {mul_p[31:0], 32'd0}; n_mp = MP_HL; end
                    MP_HL: begin n_prod = r_prod + {mul_p[31:0], 32'd0}; n_mp = MP_DONE; end
                    default: n_mp = r_mp;
                endcase
                if (r_op == eia_pkg::OP_POW && r_mp == MP_HL) begin
                    n_mp = MP_IDLE;
                    if (n_sq) begin
                        n_base = (r_prod + {mul_p[31:0], 32'd0}) & mask;
                        n_rem  = r_rem >> 1;
                        n_cnt  = r_cnt - 1'b1;
                        n_sq   = 1'b0;
                    end else begin
                        n_acc = (r_prod + {mul_p[31:0], 32'd0}) & mask;
                        n_sq  = 1'b1;
                    end
                end
            end else if (r_op == eia_pkg::OP_POW) begin
                // Start a multiply (r*base) or a square (base*base)
                if (!r_sq && !r_rem[0]) n_sq = 1'b1;
                else begin
                    n_a  = r_sq ? r_base : r_acc;
                    n_b  = r_base;
                    n_mp = MP_LL;
                    n_sq = r_sq;
                end
            end else if (r_op == eia_pkg::OP_DIV) begin
                // Restoring divide step
                n_acc = {r_acc[W-2:0], 1'b0};
                if (rem_sh >= {1'b0, r_b}) begin
                    n_rem = W'(rem_sh - {1'b0, r_b});
                    n_acc[0] = 1'b1;
                end else begin
                    n_rem = rem_sh[W-1:0];
                end
                n_cnt = r_cnt - 1'b1;
            end
        end else if (i_cmd.finish) begin
            case (r_op)
                eia_pkg::OP_MUL: n_res = r_prod & mask;
                eia_pkg::OP_DIV: n_res = r_dz ? '0 :
                    ((r_neg ? (W'(0) - r_acc) : r_acc) & eia_pkg::elem_mask(r_et));
                eia_pkg::OP_POW: n_res = r_zero ? '0 : (r_acc & eia_pkg::elem_mask(r_et));
                default: n_res = r_res;
            endcase
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mp <= MP_IDLE;
            r_sq <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_mp <= n_mp;
            r_sq <= n_sq;
            r_cnt <= n_cnt;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_operation;
            r_et <= i_elem_type;
        end
        r_a <= n_a; r_b <= n_b; r_acc <= n_acc; r_rem <= n_rem; r_base <= n_base;
        r_prod <= n_prod; r_neg <= n_neg; r_dz <= n_dz; r_zero <= n_zero; r_res <= n_res;
    end

    // Status: pow ends when no exponent bits remain or it is negative.
    always_comb begin
        o_status.iterative = (r_op == eia_pkg::OP_MUL) || (r_op == eia_pkg::OP_DIV && !r_dz) ||
                             (r_op == eia_pkg::OP_POW && !r_zero);
        case (r_op)
            eia_pkg::OP_MUL: o_status.done = (r_mp == MP_DONE);
            eia_pkg::OP_DIV: o_status.done = (r_cnt == '0);
            eia_pkg::OP_POW: o_status.done = (r_mp == MP_IDLE) && !r_sq && (r_rem == '0);
            default:         o_status.done = 1'b1;
        endcase
    end

    assign o_result   = r_res;
    assign o_div_zero = r_dz && (r_op == eia_pkg::OP_DIV);

    // The step counter never exceeds 64, the widest element width.
    a_div_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 7'd64) else $error("divide counter out of range");
    // Load and step never come together.
    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.load && i_cmd.step)) else $error("load and step together");
    // The multiply phase changes only on load or step.
    a_mp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_cmd.load && !i_cmd.step) |=> $stable(r_mp)) else $error("multiply phase moved");

endmodule

// ----- src/eia_ctrl.sv -----
// ----------------------------------------------------------------------------
// eia_ctrl
// Controller: accepts a transaction, runs the datapath, presents the result.
// ----------------------------------------------------------------------------
module eia_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  eia_pkg::t_status  i_status,
    output eia_pkg::t_cmd     o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0] r_state, n_state;

    // Next-state logic
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RUN;
                end
            end
            S_RUN: begin
                if (!i_status.iterative || i_status.done) n_state = S_FIN;
                else o_cmd.step = 1'b1;
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    // Output is held until taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid) else $error("result dropped");
    // An accepted transaction always starts the datapath.
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_RUN)) else $error("accept lost");
    // Finish is issued only right before the result is shown.
    a_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> o_out_valid) else $error("finish without output");

endmodule

// ----- src/elementwise_integer_alu.sv -----
// ----------------------------------------------------------------------------
// elementwise_integer_alu
// Element-wise integer ALU: add, sub, mul, div, pow and negate on 8 to 64
// bit signed or unsigned elements, results wrapped to the element width.
// ----------------------------------------------------------------------------
//  Channel  Dir  Payload
//  in       in   lhs_value[63:0], rhs_value[63:0], last_element
//  out      out  result_value[63:0], divide_by_zero, last_out
//  cfg      in   i_cfg_we, i_cfg_index, i_cfg_data[2:0]
//
// One transaction at a time. Add, sub and negate pass the run and finish
// states to the output handshake; multiply uses three 32x32 products.
// Divide gives a quotient bit per step (radix-2 restoring). Power, on the
// shared multiplier, squares per exponent bit and multiplies per set bit.
// Synchronous active-low reset sets operation to add and type to i32.
// A stalled result holds the block; no new transaction is taken meanwhile.
module elementwise_integer_alu (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [2:0]  i_cfg_data,
    eia_in_if.sink      in_ch,
    eia_out_if.source   out_ch
);

    logic [2:0]        r_operation, r_elem_type;
    logic              r_last;
    eia_pkg::t_cmd     cmd;
    eia_pkg::t_status  status;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_operation <= eia_pkg::OP_ADD;
            r_elem_type <= eia_pkg::ELEM_TYPE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                eia_pkg::CFG_OPERATION: r_operation <= i_cfg_data;
                eia_pkg::CFG_ELEM_TYPE: r_elem_type <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Last flag follows the transaction
    always_ff @(posedge i_clk) begin
        if (cmd.load) r_last <= in_ch.last_element;
    end

    eia_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_ch.valid),
        .o_in_ready  (in_ch.ready),
        .o_out_valid (out_ch.valid),
        .i_out_ready (out_ch.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    eia_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_operation (r_operation),
        .i_elem_type (r_elem_type),
        .i_lhs       (in_ch.lhs_value),
        .i_rhs       (in_ch.rhs_value),
        .o_status    (status),
        .o_result    (out_ch.result_value),
        .o_div_zero  (out_ch.divide_by_zero)
    );

    assign out_ch.last_out = r_last;

endmodule
